// ----- sv/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  // Hue input
  localparam int HUE_BITS     = 9;
  localparam int SECTOR_DEG   = 60;
  localparam int REM_BITS     = 6;
  // Largest hue / 60 that a 9-bit hue can give, and bits to hold it
  localparam int MAX_HUE_IDX  = ((1 << HUE_BITS) - 1) / SECTOR_DEG;
  localparam int HUE_IDX_BITS = $clog2(MAX_HUE_IDX + 1);

  // Register stages from input transaction to output register
  localparam int PIPE_STAGES  = 7;

  // Lanes of the shared-form divider datapath
  localparam int NUM_LANES = 3;
  localparam int LANE_P    = 0;
  localparam int LANE_Q    = 1;
  localparam int LANE_T    = 2;

  typedef logic [HUE_BITS-1:0]     hue_t;
  typedef logic [REM_BITS-1:0]     rem_t;
  typedef logic [HUE_IDX_BITS-1:0] hue_idx_t;

  // 60-degree sectors of the color wheel
  typedef enum logic [2:0] {
    SEC_RY,   // red to yellow
    SEC_YG,   // yellow to green
    SEC_GC,   // green to cyan
    SEC_CB,   // cyan to blue
    SEC_BM,   // blue to magenta
    SEC_MR    // magenta to red, also every hue of 300 and up
  } sector_t;

endpackage

// ----- sv/hsv2rgb_if.sv -----
interface hsv2rgb_in_if #(
  parameter int CHANNEL_BITS = 8
);
  import hsv2rgb_pkg::*;

  logic                    valid;
  logic                    ready;
  hue_t                    hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- sv/hsv_to_rgb_converter.sv -----
// Channel     Dir   Interface        Payload
// ----------  ----  ---------------  -----------------------------------------
// pixel_in    sink  hsv2rgb_in_if    hue[8:0], saturation, brightness
// pixel_out   src   hsv2rgb_out_if   red, green, blue
//
// One transaction in, one transaction out. Throughput is one pixel per clock
// while pixel_out is not stalled. Each pixel passes through the registered stages
// decode, factors, numerators, reciprocal partial products, quotient estimate,
// back-multiply, and correct/select into the output register.
// rst (synchronous) empties the pipeline; pixel_in.ready is low during reset.
// Each stage holds while it is full and the one after it is stalled, so a stall on
// pixel_out only backs up as far as it must; empty stages still fill.
module hsv_to_rgb_converter #(
  parameter int CHANNEL_BITS = 8
) (
  input logic           clk,
  input logic           rst,
  hsv2rgb_in_if.sink    pixel_in,
  hsv2rgb_out_if.source pixel_out
);
  import hsv2rgb_pkg::*;

  // Datapath widths
  localparam int FW = CHANNEL_BITS + REM_BITS;   // factor, holds 60*M
  localparam int NW = 2 * FW - 2 * REM_BITS + REM_BITS; // numerator, V*60*M
  localparam int RW = CHANNEL_BITS + 2;          // reciprocal
  localparam int HW = NW / 2;                    // split point of numerator
  localparam int PPW = (NW - HW) + RW;           // partial product
  localparam int PW = NW + RW + 1;               // summed product

  // Division by 60*M done as multiply by floor(2^NW / (60*M)); the estimate
  // is low by at most one and gets a single compare-and-add fixup.
  localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam longint unsigned DIV    = SECTOR_DEG * CH_MAX;
  localparam longint unsigned RECIP  = (64'd1 << NW) / DIV;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX_C = CHANNEL_BITS'(CH_MAX);
  localparam logic [FW-1:0]           DIV_F    = FW'(DIV);
  localparam logic [NW-1:0]           DIV_N    = NW'(DIV);
  localparam logic [RW-1:0]           RECIP_C  = RW'(RECIP);
  localparam logic [REM_BITS-1:0]     DEG_C    = REM_BITS'(SECTOR_DEG);

  // ---------------------------------------------------------------------
  // Flow control: per-stage valid and advance
  // ---------------------------------------------------------------------
  logic [PIPE_STAGES:1] vld;
  logic [PIPE_STAGES:1] adv;
  logic                 in_acc;

  always_comb begin
    adv[PIPE_STAGES] = !vld[PIPE_STAGES] || pixel_out.ready;
    for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel_in.ready  = adv[1] && !rst;
  assign in_acc          = pixel_in.valid && pixel_in.ready;
  assign pixel_out.valid = vld[PIPE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_acc;
      end
      for (int k = 2; k <= PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: split hue into sector and remainder
  // ---------------------------------------------------------------------
  hue_idx_t hue_idx;
  rem_t     hue_rem;
  sector_t  hue_sector;

  always_comb begin
    hue_idx = '0;
    for (int k = 1; k <= MAX_HUE_IDX; k++) begin
      if (pixel_in.hue >= HUE_BITS'(k * SECTOR_DEG)) begin
        hue_idx = HUE_IDX_BITS'(k);
      end
    end
    hue_rem = REM_BITS'(pixel_in.hue - HUE_BITS'(hue_idx * SECTOR_DEG));
    // Hues of 300 and beyond all fold into the last sector
    if (hue_idx >= HUE_IDX_BITS'(SEC_MR)) begin
      hue_sector = SEC_MR;
    end else begin
      hue_sector = sector_t'(hue_idx[2:0]);
    end
  end

  sector_t                 s1_sector;
  rem_t                    s1_rem;
  logic [CHANNEL_BITS-1:0] s1_sat;
  logic [CHANNEL_BITS-1:0] s1_val;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_sector <= hue_sector;
      s1_rem    <= hue_rem;
      s1_sat    <= pixel_in.saturation;
      s1_val    <= pixel_in.brightness;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: factors over the common divisor 60*M
  //   p: 60*(M-S)   q: 60*M - S*rem   t: 60*M - S*(60-rem)
  // Zero saturation makes every factor 60*M, so grey falls out directly.
  // ---------------------------------------------------------------------
  logic [FW-1:0]           fac [NUM_LANES];
  logic [FW-1:0]           s2_fac [NUM_LANES];
  sector_t                 s2_sector;
  logic [CHANNEL_BITS-1:0] s2_val;

  always_comb begin
    fac[LANE_P] = FW'(CH_MAX_C - s1_sat) * FW'(DEG_C);
    fac[LANE_Q] = DIV_F - FW'(s1_sat) * FW'(s1_rem);
    fac[LANE_T] = DIV_F - FW'(s1_sat) * FW'(DEG_C - s1_rem);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_fac    <= fac;
      s2_sector <= s1_sector;
      s2_val    <= s1_val;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: numerators V * factor
  // ---------------------------------------------------------------------
  logic [NW-1:0]           s3_num [NUM_LANES];
  sector_t                 s3_sector;
  logic [CHANNEL_BITS-1:0] s3_val;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s3_num[k] <= NW'(s2_val) * NW'(s2_fac[k]);
      end
      s3_sector <= s2_sector;
      s3_val    <= s2_val;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: numerator * reciprocal, as two half-width partial products
  // ---------------------------------------------------------------------
  logic [PPW-1:0]          s4_pph [NUM_LANES];
  logic [PPW-1:0]          s4_ppl [NUM_LANES];
  logic [NW-1:0]           s4_num [NUM_LANES];
  sector_t                 s4_sector;
  logic [CHANNEL_BITS-1:0] s4_val;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s4_pph[k] <= PPW'(s3_num[k][NW-1:HW]) * PPW'(RECIP_C);
        s4_ppl[k] <= PPW'(s3_num[k][HW-1:0]) * PPW'(RECIP_C);
      end
      s4_num    <= s3_num;
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum partial products, take quotient estimate
  // ---------------------------------------------------------------------
  logic [PW-1:0]           prod [NUM_LANES];
  logic [CHANNEL_BITS-1:0] s5_qe [NUM_LANES];
  logic [NW-1:0]           s5_num [NUM_LANES];
  sector_t                 s5_sector;
  logic [CHANNEL_BITS-1:0] s5_val;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      prod[k] = PW'({s4_pph[k], {HW{1'b0}}}) + PW'(s4_ppl[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s5_qe[k] <= prod[k][NW +: CHANNEL_BITS];
      end
      s5_num    <= s4_num;
      s5_sector <= s4_sector;
      s5_val    <= s4_val;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: multiply estimate back by the divisor
  // ---------------------------------------------------------------------
  logic [NW-1:0]           s6_qd [NUM_LANES];
  logic [CHANNEL_BITS-1:0] s6_qe [NUM_LANES];
  logic [NW-1:0]           s6_num [NUM_LANES];
  sector_t                 s6_sector;
  logic [CHANNEL_BITS-1:0] s6_val;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s6_qd[k] <= NW'(s5_qe[k]) * DIV_N;
      end
      s6_qe     <= s5_qe;
      s6_num    <= s5_num;
      s6_sector <= s5_sector;
      s6_val    <= s5_val;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: fix the estimate, route lanes to channels by sector
  // ---------------------------------------------------------------------
  logic [NW-1:0]           resid [NUM_LANES];
  logic [CHANNEL_BITS-1:0] lane [NUM_LANES];
  logic [CHANNEL_BITS-1:0] red_next;
  logic [CHANNEL_BITS-1:0] green_next;
  logic [CHANNEL_BITS-1:0] blue_next;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      resid[k] = s6_num[k] - s6_qd[k];
      lane[k]  = s6_qe[k] + CHANNEL_BITS'(resid[k] >= DIV_N);
    end
    unique case (s6_sector)
      SEC_RY: begin
        red_next = s6_val;       green_next = lane[LANE_T]; blue_next = lane[LANE_P];
      end
      SEC_YG: begin
        red_next = lane[LANE_Q]; green_next = s6_val;       blue_next = lane[LANE_P];
      end
      SEC_GC: begin
        red_next = lane[LANE_P]; green_next = s6_val;       blue_next = lane[LANE_T];
      end
      SEC_CB: begin
        red_next = lane[LANE_P]; green_next = lane[LANE_Q]; blue_next = s6_val;
      end
      SEC_BM: begin
        red_next = lane[LANE_T]; green_next = lane[LANE_P]; blue_next = s6_val;
      end
      SEC_MR: begin
        red_next = s6_val;       green_next = lane[LANE_P]; blue_next = lane[LANE_Q];
      end
      default: begin
        red_next = s6_val;       green_next = lane[LANE_P]; blue_next = lane[LANE_Q];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[PIPE_STAGES]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign pixel_out.red   = red;
  assign pixel_out.green = green;
  assign pixel_out.blue  = blue;

endmodule

// ----- sv/hsv2rgb_checker.sv -----
module hsv2rgb_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] red,
  input logic [CHANNEL_BITS-1:0] green,
  input logic [CHANNEL_BITS-1:0] blue
);
  import hsv2rgb_pkg::*;

  localparam int CW = $clog2(PIPE_STAGES + 2);

  logic          in_acc;
  logic          out_acc;
  logic          flow;
  logic [CW-1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign flow    = out_ready && !rst;

  // Transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CW'(in_acc) - CW'(out_acc);
    end
  end

  // Output held steady while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue))
    else $error("output changed while stalled");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Free-flowing output: a transaction appears after the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc ##1 flow ##1 flow ##1 flow ##1 flow ##1 flow ##1 flow |=> out_valid)
    else $error("result missing after pipeline latency");

  // No result without a pending transaction
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != '0)
    else $error("result without input transaction");

  // Never more in flight than the pipeline holds
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    pending <= CW'(PIPE_STAGES))
    else $error("more transactions in flight than pipeline stages");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_hsv2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_in.valid),
  .in_ready  (pixel_in.ready),
  .out_valid (pixel_out.valid),
  .out_ready (pixel_out.ready),
  .red       (pixel_out.red),
  .green     (pixel_out.green),
  .blue      (pixel_out.blue)
);

// ----- tb/tb_hsv_to_rgb_converter.sv -----
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  localparam int CHANNEL_BITS = 8;
  localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;
  // Run limit: ~1575 transactions, each allowed a long source gap, a long
  // sink stall and the pipeline depth, then taken several times over.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = PIPE_STAGES * 4;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicts the color of every accepted pixel and checks the
  // output transactions against those predictions in order.
  // -------------------------------------------------------------------------
  class rgb_scoreboard;
    rgb_t        pending[$];
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_grey;
    int unsigned n_wrap;

    // Exact integer form of p = v(1-s), q = v(1-sf), t = v(1-s(1-f)),
    // each scaled to full scale and truncated.
    function rgb_t predict_rgb(hue_t h, chan_t s, chan_t v);
      longint unsigned hv, sv, vv, rem, full, sec_idx, pv, qv, tv;
      sector_t         sec;
      rgb_t            c;
      hv      = h;
      sv      = s;
      vv      = v;
      full    = SECTOR_DEG * CH_MAX;
      rem     = hv % SECTOR_DEG;
      sec_idx = hv / SECTOR_DEG;
      // hues of 360 and up fold into the magenta-to-red assignment
      sec     = (sec_idx >= SEC_MR) ? SEC_MR : sector_t'(sec_idx);
      pv      = (vv * (CH_MAX - sv)) / CH_MAX;
      qv      = (vv * (full - sv * rem)) / full;
      tv      = (vv * (full - sv * (SECTOR_DEG - rem))) / full;
      if (sv == 0) begin
        c = '{red: v, green: v, blue: v};
      end else begin
        case (sec)
          SEC_RY:  c = '{red: chan_t'(vv), green: chan_t'(tv), blue: chan_t'(pv)};
          SEC_YG:  c = '{red: chan_t'(qv), green: chan_t'(vv), blue: chan_t'(pv)};
          SEC_GC:  c = '{red: chan_t'(pv), green: chan_t'(vv), blue: chan_t'(tv)};
          SEC_CB:  c = '{red: chan_t'(pv), green: chan_t'(qv), blue: chan_t'(vv)};
          SEC_BM:  c = '{red: chan_t'(tv), green: chan_t'(pv), blue: chan_t'(vv)};
          default: c = '{red: chan_t'(vv), green: chan_t'(pv), blue: chan_t'(qv)};
        endcase
      end
      return c;
    endfunction

    function void note_pixel(hue_t h, chan_t s, chan_t v);
      pending.push_back(predict_rgb(h, s, v));
      if (s == 0) n_grey++;
      if (h >= 360) n_wrap++;
    endfunction

    function void check_color(chan_t r, chan_t g, chan_t b);
      rgb_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: output transaction with nothing outstanding: r=%0d g=%0d b=%0d",
                 $time, r, g, b);
        n_errors++;
        return;
      end
      exp_c = pending.pop_front();
      n_checked++;
      if (r !== exp_c.red) begin
        $display("%0t: red expected %0d got %0d", $time, exp_c.red, r);
        n_errors++;
      end
      if (g !== exp_c.green) begin
        $display("%0t: green expected %0d got %0d", $time, exp_c.green, g);
        n_errors++;
      end
      if (b !== exp_c.blue) begin
        $display("%0t: blue expected %0d got %0d", $time, exp_c.blue, b);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  hsv2rgb_in_if  #(.CHANNEL_BITS(CHANNEL_BITS)) pix_in ();
  hsv2rgb_out_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix_out ();

  hsv_to_rgb_converter #(.CHANNEL_BITS(CHANNEL_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_in),
    .pixel_out (pix_out)
  );

  rgb_scoreboard sb;

  // sink_stalls enables random back-pressure on pixel_out
  bit          sink_stalls;
  int unsigned stall_left;
  int unsigned n_stall_cycles;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Watchdog: a hung pipeline or a lost transaction ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.pending.size());
      $display("tb_hsv_to_rgb_converter: FAIL");
      $finish;
    end
  end

  // Sink side: ready changes only on the falling edge. With stalls enabled a
  // stall of random length starts now and then; otherwise ready stays high.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      n_stall_cycles++;
      pix_out.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      pix_out.ready <= (stall_left == 0);
      if (stall_left > 0) begin
        stall_left--;
        n_stall_cycles++;
      end
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  // Monitor: sample both channels at the rising edge. The output is checked
  // before the input is noted; the pipeline is at least one stage deep, so a
  // pixel accepted on this edge can never be the one leaving on it.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_out.valid && pix_out.ready)
        sb.check_color(pix_out.red, pix_out.green, pix_out.blue);
      if (pix_in.valid && pix_in.ready)
        sb.note_pixel(pix_in.hue, pix_in.saturation, pix_in.brightness);
    end
  end

  // Present one pixel, optionally after a random idle gap, and hold it until
  // the transaction completes. valid is only touched on falling edges.
  task automatic send_pixel(input hue_t h, input chan_t s, input chan_t v,
                            input bit with_gap);
    int unsigned gap;
    gap = with_gap ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid      <= 1'b1;
    pix_in.hue        <= h;
    pix_in.saturation <= s;
    pix_in.brightness <= v;
    do @(posedge clk); while (!(pix_in.valid && pix_in.ready));
  endtask

  // Random pixel: mostly hues on the wheel, some pinned to sector edges,
  // some past 359; saturation and brightness lean toward zero and full scale.
  task automatic send_random(input bit with_gap);
    hue_t  h;
    chan_t s;
    chan_t v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75)      h = hue_t'($urandom_range(0, 359));
    else if (r < 88) h = hue_t'(SECTOR_DEG * $urandom_range(0, 5) +
                                ($urandom_range(0, 1) ? SECTOR_DEG - 1 : 0));
    else             h = hue_t'($urandom_range(360, (1 << HUE_BITS) - 1));
    r = $urandom_range(0, 99);
    if (r < 8)       s = '0;
    else if (r < 16) s = chan_t'(CH_MAX);
    else             s = chan_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 6)       v = '0;
    else if (r < 14) v = chan_t'(CH_MAX);
    else             v = chan_t'($urandom);
    send_pixel(h, s, v, with_gap);
  endtask

  // Stop sending and wait until every predicted color has come out.
  task automatic drain();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    // Known values on every input from time zero.
    rst               = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.hue        = '0;
    pix_in.saturation = '0;
    pix_in.brightness = '0;
    pix_out.ready     = 1'b0;
    sink_stalls       = 1'b0;
    stall_left        = 0;
    n_stall_cycles    = 0;
    cycle_count       = 0;
    sb                = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every sector at both ends at full saturation and value,
    // grey, black, hues past the wheel, and the smallest nonzero channels.
    send_pixel(9'd0,   8'd255, 8'd255, 1'b0);
    send_pixel(9'd59,  8'd255, 8'd255, 1'b0);
    send_pixel(9'd60,  8'd255, 8'd255, 1'b0);
    send_pixel(9'd119, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd120, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd179, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd180, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd239, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd240, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd299, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd300, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd359, 8'd255, 8'd255, 1'b0);
    // grey at several hues and values
    send_pixel(9'd0,   8'd0,   8'd255, 1'b0);
    send_pixel(9'd200, 8'd0,   8'd77,  1'b0);
    send_pixel(9'd511, 8'd0,   8'd0,   1'b0);
    // black at full saturation
    send_pixel(9'd90,  8'd255, 8'd0,   1'b0);
    // hues past 359 fold into the last sector
    send_pixel(9'd360, 8'd200, 8'd180, 1'b0);
    send_pixel(9'd420, 8'd255, 8'd255, 1'b0);
    send_pixel(9'd479, 8'd128, 8'd255, 1'b0);
    send_pixel(9'd511, 8'd255, 8'd255, 1'b0);
    // tiny channels and mid-sector truncation
    send_pixel(9'd30,  8'd1,   8'd1,   1'b0);
    send_pixel(9'd150, 8'd1,   8'd255, 1'b0);
    send_pixel(9'd271, 8'd170, 8'd129, 1'b0);
    send_pixel(9'd333, 8'd254, 8'd254, 1'b0);

    // Random with gaps on both sides.
    sink_stalls = 1'b1;
    repeat (700) send_random(1'b1);

    // Let the pipeline run dry before carrying on.
    drain();

    // Full rate: no source gaps, sink always ready.
    sink_stalls = 1'b0;
    repeat (400) send_random(1'b0);

    // Full-rate source against a stalling sink, then gaps again.
    sink_stalls = 1'b1;
    repeat (150) send_random(1'b0);
    repeat (300) send_random(1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected colors never arrived", $time, sb.pending.size());
      sb.n_errors++;
    end

    $display("Checked %0d pixels: %0d grey, %0d with hue past 359, all six sectors edges",
             sb.n_checked, sb.n_grey, sb.n_wrap);
    $display("Ran %0d cycles with %0d sink stall cycles and source gaps, %0d mismatches",
             cycle_count, n_stall_cycles, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_hsv_to_rgb_converter: PASS");
    end else begin
      $display("tb_hsv_to_rgb_converter: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_if.sv
sv/hsv_to_rgb_converter.sv
sv/hsv2rgb_checker.sv
tb/tb_hsv_to_rgb_converter.sv
